>>> design/mbq_pkg.sv
// Shared constants and types for the multichannel biquad filter.
package mbq_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 32;
  localparam int FRAC_BITS    = 28;
  localparam int CHAN_BITS    = 3;
  localparam int NUM_CHANNELS = 1 << CHAN_BITS;
  localparam int REG_IDX_BITS = 3;
  localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS     = PROD_BITS + 3;
  localparam int Q_BITS       = ACC_BITS - FRAC_BITS;

  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) <<< FRAC_BITS;
  localparam logic signed [ACC_BITS-1:0]  ROUND_HALF = ACC_BITS'(1) <<< (FRAC_BITS - 1);

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x1;
    logic signed [SAMPLE_BITS-1:0] x2;
    logic signed [SAMPLE_BITS-1:0] y1;
    logic signed [SAMPLE_BITS-1:0] y2;
  } hist_t;

endpackage

>>> design/multichannel_biquad_filter.sv
// Multichannel direct form I biquad filter with per-channel history in RAM.
// An accepted input word passes the stage 1, stage 2 and output registers before its output word is valid.
// Throughput: one word per cycle while out_stall_i does not hold the pipeline, any channel order; the y1 feedback path
// (one multiply, the five-term sum and saturation) sets the clock.
// History RAM reads are registered; same-channel words forward in flight.
// Reset clears control and per-channel valid bits (history reads as zero); b0 = 1.0, others 0.
module multichannel_biquad_filter import mbq_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [REG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [COEF_BITS-1:0]          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic [CHAN_BITS-1:0]          chan_in_i,
  input  logic                          block_end_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic [CHAN_BITS-1:0]          chan_out_o,
  output logic                          block_end_out_o
);

  logic signed [COEF_BITS-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;

  hist_t                    hist_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  ent_v_q;

  logic                          adv;
  logic                          s1_v_q, s2_v_q, out_valid_q;
  logic                          rd_v_q, wb_v_q;
  hist_t                         rd_q, wb_q;
  logic [CHAN_BITS-1:0]          wb_chan_q;

  logic signed [SAMPLE_BITS-1:0] s1_x_q;
  logic [CHAN_BITS-1:0]          s1_chan_q;
  logic                          s1_be_q;

  logic signed [PROD_BITS-1:0]   s2_pb0_q, s2_pb1_q, s2_pb2_q, s2_pa2_q;
  logic signed [SAMPLE_BITS-1:0] s2_x_q, s2_x1_q, s2_y1_q;
  logic [CHAN_BITS-1:0]          s2_chan_q;
  logic                          s2_be_q;

  hist_t                         h1;
  logic signed [SAMPLE_BITS-1:0] s1_x1, s1_x2, s1_y2;
  logic signed [PROD_BITS-1:0]   pb0, pb1, pb2, pa2, pa1;
  logic signed [SAMPLE_BITS-1:0] s2_y1, y_d;
  logic signed [ACC_BITS-1:0]    acc;
  logic [Q_BITS-1:0]             q;
  logic [Q_BITS-SAMPLE_BITS:0]   q_top;
  hist_t                         wb_d;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= COEF_ONE;
      b1_q <= '0;
      b2_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_B0:  b0_q <= cfg_wdata_i;
        REG_B1:  b1_q <= cfg_wdata_i;
        REG_B2:  b2_q <= cfg_wdata_i;
        REG_A1:  a1_q <= cfg_wdata_i;
        REG_A2:  a2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign adv        = ~s2_v_q | ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~adv;

  // stage 1: merge RAM data with in-flight writes, feedforward products
  always_comb begin
    h1 = rd_v_q ? rd_q : '0;
    if (wb_v_q && (wb_chan_q == s1_chan_q)) begin
      h1 = wb_q;
    end
    if (s2_v_q && (s2_chan_q == s1_chan_q)) begin
      h1.x1 = s2_x_q;
      h1.x2 = s2_x1_q;
      h1.y2 = s2_y1;
    end
    s1_x1 = h1.x1;
    s1_x2 = h1.x2;
    s1_y2 = h1.y2;
    pb0   = b0_q * s1_x_q;
    pb1   = b1_q * s1_x1;
    pb2   = b2_q * s1_x2;
    pa2   = a2_q * s1_y2;
  end

  // stage 2: feedback product, sum, round, saturate
  always_comb begin
    s2_y1 = (wb_v_q && (wb_chan_q == s2_chan_q)) ? wb_q.y1 : s2_y1_q;
    pa1   = a1_q * s2_y1;
    acc   = ACC_BITS'(s2_pb0_q) + ACC_BITS'(s2_pb1_q) + ACC_BITS'(s2_pb2_q)
          - ACC_BITS'(pa1) - ACC_BITS'(s2_pa2_q) + ROUND_HALF;
    q     = acc[ACC_BITS-1:FRAC_BITS];
    q_top = q[Q_BITS-1:SAMPLE_BITS-1];
    if ((&q_top) || ~(|q_top)) begin
      y_d = q[SAMPLE_BITS-1:0];
    end else if (q[Q_BITS-1]) begin
      y_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    wb_d.x1 = s2_x_q;
    wb_d.x2 = s2_x1_q;
    wb_d.y1 = y_d;
    wb_d.y2 = s2_y1;
  end

  // history RAM
  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q) begin
      hist_mem[s2_chan_q] <= wb_d;
    end
    if (adv) begin
      rd_q <= hist_mem[chan_in_i];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q     <= '0;
      rd_v_q      <= 1'b0;
      wb_v_q      <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s2_v_q | (out_valid_q & out_stall_i);
      if (adv) begin
        s1_v_q <= in_valid_i;
        s2_v_q <= s1_v_q;
        rd_v_q <= ent_v_q[chan_in_i];
        if (s2_v_q) begin
          ent_v_q[s2_chan_q] <= 1'b1;
          wb_v_q             <= 1'b1;
        end
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q    <= sample_in_i;
      s1_chan_q <= chan_in_i;
      s1_be_q   <= block_end_in_i;
      s2_pb0_q  <= pb0;
      s2_pb1_q  <= pb1;
      s2_pb2_q  <= pb2;
      s2_pa2_q  <= pa2;
      s2_x_q    <= s1_x_q;
      s2_x1_q   <= s1_x1;
      s2_y1_q   <= h1.y1;
      s2_chan_q <= s1_chan_q;
      s2_be_q   <= s1_be_q;
      if (s2_v_q) begin
        wb_q            <= wb_d;
        wb_chan_q       <= s2_chan_q;
        sample_out_o    <= y_d;
        chan_out_o      <= s2_chan_q;
        block_end_out_o <= s2_be_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
